// ----- rtl/core/bdq_pkg.sv -----
// bdq_pkg: shared types and codes for the bounded deque block
// beat payload structs, operation and status codes, sequencer states
// no dependencies
package bdq_pkg;

  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_CLEAR      = 3'd4;
  localparam logic [2:0] FN_QUERY      = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  func;
    logic signed [31:0] key;
  } bdq_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [8:0]  entry_count;
    logic signed [31:0] total_sum;
    logic        [8:0]  match_count;
    logic signed [31:0] max_value;
    logic               max_valid;
  } bdq_out_t;

  typedef struct packed {
    logic               clr;
    logic               vld;
    logic signed [31:0] key;
  } bdq_scan_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_DRAIN,
    S_QOUT
  } bdq_state_t;

endpackage

// ----- rtl/core/bdq_stats.sv -----
// bdq_stats: match counter and running maximum for the query walk
// takes one stored entry per cycle, while scan.vld is set, from the entry memory read port
// depends on bdq_pkg
module bdq_stats #(
  parameter int CNT_W = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bdq_pkg::bdq_scan_t      scan,
  input  logic             [31:0] rd_data,
  output logic        [CNT_W-1:0] match_cnt,
  output logic signed      [31:0] max_val,
  output logic                    max_ok
);
  import bdq_pkg::*;

  logic        [CNT_W-1:0] match_r, match_nxt;
  logic signed [31:0]      max_r, max_nxt;
  logic                    max_ok_r, max_ok_nxt;

  always_comb begin
    match_nxt  = match_r;
    max_nxt    = max_r;
    max_ok_nxt = max_ok_r;
    if (scan.clr) begin
      match_nxt  = '0;
      max_nxt    = '0;
      max_ok_nxt = 1'b0;
    end else if (scan.vld) begin
      if (rd_data == scan.key) begin
        match_nxt = match_r + CNT_W'(1);
      end
      if (!max_ok_r || ($signed(rd_data) > max_r)) begin
        max_nxt    = $signed(rd_data);
        max_ok_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r  <= '0;
      max_r    <= '0;
      max_ok_r <= 1'b0;
    end else begin
      match_r  <= match_nxt;
      max_r    <= max_nxt;
      max_ok_r <= max_ok_nxt;
    end
  end

  assign match_cnt = match_r;
  assign max_val   = max_r;
  assign max_ok    = max_ok_r;

endmodule

// ----- rtl/core/bounded_deque_with_stats.sv -----
// bounded_deque_with_stats: bounded double-ended queue of signed 32-bit values
// with running sum and a query walk for key matches and the maximum
// depends on bdq_pkg and bdq_stats
//
// usage: drive in_data and raise start; the beat is taken on an edge where
// busy is low. each beat yields exactly one result beat on out_data, marked
// by out_valid for a single cycle; the receiver cannot stall and must take it.
// entries live in one DEPTH x 32 synchronous memory with a registered read port.
// steps from the accepting edge to out_valid:
//   push, clear, unused codes, query on empty: result registered from the execute state
//   pop: memory read of the removed entry, then sum update
//   query: one memory read per held entry, then a drain state and the output state
// busy drops in the cycle out_valid is shown, so the next beat can be taken
// then; the query walk is the longest beat.
// reset (rst_n low, synchronous) empties the deque and zeros the sum; memory
// contents are not cleared and are never read before being written.
module bounded_deque_with_stats #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bdq_pkg::bdq_in_t  in_data,
  output logic              out_valid,
  output bdq_pkg::bdq_out_t out_data
);
  import bdq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] base,
                                            input logic [PW-1:0] off);
    logic [PW:0] s;
    s = (PW+1)'(base) + (PW+1)'(off);
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;
  logic        mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  bdq_state_t         state_r, state_nxt;
  bdq_in_t            in_r, in_nxt;
  logic [PW-1:0]      fp_r, fp_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] sum_r, sum_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [PW-1:0]      sp_r, sp_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  bdq_out_t           out_r, out_nxt;

  bdq_scan_t          scan;
  logic [CW-1:0]      match_cnt;
  logic signed [31:0] max_val;
  logic               max_ok;

  logic               emit;
  logic [1:0]         emit_status;
  logic               is_full, is_empty, is_query;

  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);
  assign is_query = (in_r.func == FN_QUERY);

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    fp_nxt        = fp_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    sp_nxt        = sp_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = fp_r;
    mem_wdata     = in_r.key;
    mem_re        = 1'b0;
    mem_raddr     = fp_r;
    scan.clr      = 1'b0;
    scan.vld      = rd_vld_r;
    scan.key      = in_r.key;
    emit          = 1'b0;
    emit_status   = ST_DONE;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          scan.clr  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (in_r.func)
          FN_PUSH_FRONT: begin
            emit = 1'b1;
            if (is_full) begin
              emit_status = ST_FULL;
            end else begin
              fp_nxt    = ptr_dec(fp_r);
              mem_we    = 1'b1;
              mem_waddr = fp_nxt;
              cnt_nxt   = cnt_r + CW'(1);
              sum_nxt   = sum_r + in_r.key;
            end
          end
          FN_PUSH_BACK: begin
            emit = 1'b1;
            if (is_full) begin
              emit_status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_at(fp_r, cnt_r[PW-1:0]);
              cnt_nxt   = cnt_r + CW'(1);
              sum_nxt   = sum_r + in_r.key;
            end
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (is_empty) begin
              emit        = 1'b1;
              emit_status = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = (in_r.func == FN_POP_FRONT) ? fp_r :
                          slot_at(fp_r, PW'(cnt_r - CW'(1)));
              state_nxt = S_POP;
            end
          end
          FN_CLEAR: begin
            emit    = 1'b1;
            fp_nxt  = '0;
            cnt_nxt = '0;
            sum_nxt = '0;
          end
          FN_QUERY: begin
            if (is_empty) begin
              emit = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = fp_r;
              sp_nxt    = ptr_inc(fp_r);
              idx_nxt   = CW'(1);
              state_nxt = (cnt_r == CW'(1)) ? S_DRAIN : S_SCAN;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      S_POP: begin
        emit    = 1'b1;
        sum_nxt = sum_r - $signed(rd_data_r);
        cnt_nxt = cnt_r - CW'(1);
        if (in_r.func == FN_POP_FRONT) begin
          fp_nxt = ptr_inc(fp_r);
        end
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = sp_r;
        sp_nxt    = ptr_inc(sp_r);
        idx_nxt   = idx_r + CW'(1);
        if (idx_nxt == cnt_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        emit = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      state_nxt           = S_IDLE;
      out_valid_nxt       = 1'b1;
      out_nxt.status      = emit_status;
      out_nxt.entry_count = 9'(cnt_nxt);
      out_nxt.total_sum   = sum_nxt;
      out_nxt.match_count = is_query ? 9'(match_cnt) : '0;
      out_nxt.max_value   = is_query ? max_val : '0;
      out_nxt.max_valid   = is_query ? max_ok : 1'b0;
    end
  end

  assign rd_vld_nxt = mem_re && is_query;

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fp_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      sp_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      sp_r        <= sp_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  bdq_stats #(
    .CNT_W (CW)
  ) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan      (scan),
    .rd_data   (rd_data_r),
    .match_cnt (match_cnt),
    .max_val   (max_val),
    .max_ok    (max_ok)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("held count above depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("entry memory read and write in the same cycle");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid_r)
    else $error("beat retired without a result");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < cnt_r))
    else $error("query walk past held entries");

endmodule
